// File: rtl/core/sha1_pkg.sv
// Shared types and constants of the SHA-1 stream hasher.
package sha1_pkg;

  // Chaining values after reset and after each digest; element 0 is word a.
  localparam logic [4:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K_R0 = 32'h5A827999;
  localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_POS   = 6'd63;

  // Source of the byte shifted into the block
  typedef enum logic [1:0] {
    BYTE_MSG  = 2'd0,
    BYTE_MARK = 2'd1,
    BYTE_ZERO = 2'd2,
    BYTE_LEN  = 2'd3
  } sha1_byte_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic           shift;    // shift one byte into the block
    sha1_byte_sel_t sel;      // which byte to shift
    logic           count;    // count it as a message byte
    logic           load;     // load working variables from the chain
    logic           round;    // run one compression round
    logic           add;      // fold working variables into the chain
    logic           capture;  // capture digest, restore initial chain
  } sha1_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [5:0] fill_pos;     // next byte position in the block
    logic       last_round;   // round 79 is under way
  } sha1_stat_t;

endpackage

// File: rtl/core/sha1_if.sv
// Valid/ready channel interfaces for message items and digest items.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, input ready);
  modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                digest_word4, output ready);
endinterface

// File: rtl/core/sha1_ctrl.sv
// Controller: sequences byte intake, padding, compression and digest output.
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_has_byte,
  input  logic       in_end,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  sha1_stat_t stat,
  output sha1_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;       // message ended, padding owed
  logic   mark_r, mark_nxt;     // 0x80 marker already shifted in
  logic   wrap_r, wrap_nxt;     // marker landed past byte 55, length goes in next block
  logic   final_r, final_nxt;   // block under compression is the last one
  logic   out_valid_r, out_valid_nxt;
  logic   pos_tail;

  assign pos_tail  = stat.fill_pos inside {[6'd56:6'd63]};
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    mark_nxt  = mark_r;
    wrap_nxt  = wrap_r;
    final_nxt = final_r;
    cmd       = '0;
    cmd.sel   = BYTE_MSG;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_has_byte) begin
            cmd.shift = 1'b1;
            cmd.count = 1'b1;
          end
          if (in_has_byte && stat.fill_pos == LAST_POS) begin
            cmd.load  = 1'b1;
            fin_nxt   = in_end;
            state_nxt = ST_ROUND;
          end else if (in_end) begin
            fin_nxt   = 1'b1;
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_round) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (final_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        cmd.shift = 1'b1;
        if (!mark_r) begin
          cmd.sel = BYTE_MARK;
        end else if (!wrap_r && pos_tail) begin
          cmd.sel = BYTE_LEN;
        end else begin
          cmd.sel = BYTE_ZERO;
        end
        mark_nxt = 1'b1;
        if (!mark_r && pos_tail) begin
          wrap_nxt = 1'b1;
        end
        // close the block on its last byte
        if (stat.fill_pos == LAST_POS) begin
          cmd.load  = 1'b1;
          wrap_nxt  = 1'b0;
          final_nxt = (cmd.sel == BYTE_LEN);
          state_nxt = ST_ROUND;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.capture = 1'b1;
          fin_nxt     = 1'b0;
          mark_nxt    = 1'b0;
          wrap_nxt    = 1'b0;
          final_nxt   = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the digest item until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fin_r       <= 1'b0;
      mark_r      <= 1'b0;
      wrap_r      <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      mark_r      <= mark_nxt;
      wrap_r      <= wrap_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/sha1_dp.sv
// Datapath: block/schedule shift register, round unit, chaining and digest registers.
module sha1_dp
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  sha1_cmd_t   cmd,
  input  logic [7:0]  data_byte,
  output sha1_stat_t  stat,
  output logic [4:0][31:0] digest
);

  logic [511:0]     block_r, block_nxt;    // word 0 in the top 32 bits
  logic [5:0]       fill_pos_r, fill_pos_nxt;
  logic [60:0]      byte_cnt_r, byte_cnt_nxt;
  logic [6:0]       round_r, round_nxt;
  logic [4:0][31:0] vars_r, vars_nxt;
  logic [4:0][31:0] chain_r, chain_nxt;
  logic [4:0][31:0] digest_r, digest_nxt;

  logic [63:0] len_bits;
  logic [5:0]  len_shift;
  logic [7:0]  byte_in;
  logic [31:0] w0, w2, w8, w13, w_new;
  logic [31:0] fa, fb, fc, fd, fe, f_val, k_val, t_sum;

  assign stat.fill_pos   = fill_pos_r;
  assign stat.last_round = (round_r == LAST_ROUND);
  assign digest          = digest_r;

  // Pick the byte to shift in; length bytes go out most significant first
  assign len_bits  = {byte_cnt_r, 3'b000};
  assign len_shift = {~fill_pos_r[2:0], 3'b000};
  always_comb begin
    case (cmd.sel)
      BYTE_MSG:  byte_in = data_byte;
      BYTE_MARK: byte_in = PAD_MARK;
      BYTE_ZERO: byte_in = 8'h00;
      BYTE_LEN:  byte_in = len_bits[len_shift +: 8];
      default:   byte_in = 8'h00;
    endcase
  end

  // Message schedule taps over the sliding sixteen-word window
  assign w0    = block_r[511:480];
  assign w2    = block_r[447:416];
  assign w8    = block_r[255:224];
  assign w13   = block_r[95:64];
  assign w_new = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
                  (w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

  // Round function and constant by round group
  assign fa = vars_r[0];
  assign fb = vars_r[1];
  assign fc = vars_r[2];
  assign fd = vars_r[3];
  assign fe = vars_r[4];
  always_comb begin
    if (round_r < 7'd20) begin
      f_val = (fb & fc) | (~fb & fd);
      k_val = K_R0;
    end else if (round_r < 7'd40) begin
      f_val = fb ^ fc ^ fd;
      k_val = K_R1;
    end else if (round_r < 7'd60) begin
      f_val = (fb & fc) | (fb & fd) | (fc & fd);
      k_val = K_R2;
    end else begin
      f_val = fb ^ fc ^ fd;
      k_val = K_R3;
    end
  end
  assign t_sum = {fa[26:0], fa[31:27]} + f_val + fe + k_val + w0;

  // Next values
  always_comb begin
    block_nxt    = block_r;
    fill_pos_nxt = fill_pos_r;
    byte_cnt_nxt = byte_cnt_r;
    round_nxt    = round_r;
    vars_nxt     = vars_r;
    chain_nxt    = chain_r;
    digest_nxt   = digest_r;
    if (cmd.shift) begin
      block_nxt    = {block_r[503:0], byte_in};
      fill_pos_nxt = fill_pos_r + 6'd1;
    end
    if (cmd.count) begin
      byte_cnt_nxt = byte_cnt_r + 61'd1;
    end
    if (cmd.load) begin
      vars_nxt  = chain_r;
      round_nxt = '0;
    end
    if (cmd.round) begin
      block_nxt   = {block_r[479:0], w_new};
      vars_nxt[4] = fd;
      vars_nxt[3] = fc;
      vars_nxt[2] = {fb[1:0], fb[31:2]};
      vars_nxt[1] = fa;
      vars_nxt[0] = t_sum;
      round_nxt   = stat.last_round ? 7'd0 : round_r + 7'd1;
    end
    if (cmd.add) begin
      for (int i = 0; i < 5; i++) begin
        chain_nxt[i] = chain_r[i] + vars_r[i];
      end
    end
    if (cmd.capture) begin
      digest_nxt   = chain_r;
      chain_nxt    = H_INIT;
      byte_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_pos_r <= '0;
      byte_cnt_r <= '0;
      round_r    <= '0;
      chain_r    <= H_INIT;
    end else begin
      fill_pos_r <= fill_pos_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      round_r    <= round_nxt;
      chain_r    <= chain_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    block_r  <= block_nxt;
    vars_r   <= vars_nxt;
    digest_r <= digest_nxt;
  end

endmodule

// File: rtl/core/sha1_hash_stream.sv
// Top level of the SHA-1 stream hasher: one message byte per item, digest on the last item.
// A byte item is taken only while idle; the 64th byte of a block starts a compression
// (80 rounds of the single round unit, then the chain add), during which intake stalls.
// Last item: padding shifts in one byte per cycle up to the block end, one or two more
// compressions follow, and the digest item is offered once the digest is captured.
// Reset (rst_n low, synchronous): chain returns to the initial values, counts clear.
module sha1_hash_stream
  import sha1_pkg::*;
(
  input logic clk,
  input logic rst_n,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);

  sha1_cmd_t        cmd;
  sha1_stat_t       stat;
  logic [4:0][31:0] digest;

  sha1_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_has_byte (in_ch.has_byte),
    .in_end      (in_ch.end_of_message),
    .in_ready    (in_ch.ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .stat        (stat),
    .cmd         (cmd)
  );

  sha1_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte),
    .stat      (stat),
    .digest    (digest)
  );

  assign out_ch.digest_word0 = digest[0];
  assign out_ch.digest_word1 = digest[1];
  assign out_ch.digest_word2 = digest[2];
  assign out_ch.digest_word3 = digest[3];
  assign out_ch.digest_word4 = digest[4];

  // Rounds only run on a closed block
  a_round_block_closed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round |-> (stat.fill_pos == 6'd0))
    else $error("round step with a partly filled block");

  // Digest only after the final block is closed
  a_capture_block_closed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (stat.fill_pos == 6'd0))
    else $error("digest captured with a partly filled block");

  // Byte intake and round shifting never collide
  a_shift_round_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.shift && cmd.round))
    else $error("byte shift and round step in the same cycle");

  // A captured digest is offered on the next cycle
  a_capture_offers: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> out_ch.valid)
    else $error("captured digest not offered");

endmodule
